/* rtl/sactc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sactc_pkg: shared types and constants of the cache tag controller.
// Holds the transfer payload types, the set entry layout and the codes
// for replacement policy, access outcome and configuration registers.
// ----------------------------------------------------------------------------
package sactc_pkg;

    localparam int ADDR_BITS   = 20;
    localparam int OFFSET_BITS = 4;
    localparam int SET_BITS    = 6;
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int WAY_BITS    = 2;
    localparam int FILL_BITS   = 3;
    localparam int BLOCK_BITS  = ADDR_BITS - OFFSET_BITS;
    localparam int SEEN_BITS   = 6;
    localparam int SEEN_WIDTH  = 64;
    localparam int SEEN_ROWS   = 1 << (BLOCK_BITS - SEEN_BITS);
    localparam int ROW_BITS    = BLOCK_BITS - SEEN_BITS;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Replacement policy codes.
    localparam logic [1:0] POL_LRU    = 2'd0;
    localparam logic [1:0] POL_RANDOM = 2'd1;
    localparam logic [1:0] POL_NMRU   = 2'd2;
    localparam logic [1:0] POL_FIFO   = 2'd3;

    // Access outcome codes.
    localparam logic [1:0] OUT_HIT        = 2'd0;
    localparam logic [1:0] OUT_COMPULSORY = 2'd1;
    localparam logic [1:0] OUT_CAPACITY   = 2'd2;
    localparam logic [1:0] OUT_CONFLICT   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_REPL_POLICY    = 1'b0;
    localparam logic CFG_WRITE_ALLOCATE = 1'b1;

    // Access kind.
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           outcome;
        logic [WAY_BITS-1:0]  way;
        logic                 writeback_valid;
        logic [ADDR_BITS-1:0] writeback_address;
    } out_item_t;

    // One memory word holds the whole state of a set.
    typedef struct packed {
        logic [WAYS-1:0][ADDR_BITS-1:0] line_addr;
        logic [WAYS-1:0]                dirty;
        logic [FILL_BITS-1:0]           fill;
        logic [WAYS-1:0][WAY_BITS-1:0]  recency;
        logic [WAY_BITS-1:0]            fifo_ptr;
    } set_entry_t;

    // Moves a way to the most recent end of the recency order.
    function automatic logic [WAYS-1:0][WAY_BITS-1:0] touch_order(
        input logic [WAYS-1:0][WAY_BITS-1:0] order,
        input logic [WAY_BITS-1:0]           way
    );
        logic [WAYS-1:0][WAY_BITS-1:0] res;
        int p;
        p = WAYS - 1;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (order[i] == way)
            begin
                p = i;
            end
        end
        for (int i = 0; i < WAYS - 1; i++)
        begin
            res[i] = (i >= p) ? order[i+1] : order[i];
        end
        res[WAYS-1] = way;
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/set_assoc_cache_tag_controller_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core: tag controller of a 64-set, 4-way
// cache with LRU, random, NMRU and FIFO replacement and miss classification.
//
// Usage: an access (op, address) is a transfer on in_valid/in_ready; its one
// result (outcome, way, writeback) is a transfer on out_valid/out_ready.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and writes take effect at once.
// On accept the set memory and the seen-block memory are read; the lookup
// state then compares tags, picks a victim, writes both memories back and
// loads the result register. No new access is taken until the lookup of the
// last one is done; the read-modify-write of the set word requires this.
// The result register holds a finished result while the next access is
// accepted and read; its writeback waits until the result register is free.
// After reset the seen-block memory is cleared row by row, all 1024 rows,
// during which in_ready is low. Set state reads as its reset value through
// a valid bit per set. When out_ready is low, the result waits and the
// block stalls after at most one more accepted access.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_core
    import sactc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic [1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_BITS-1:0]   clr_reg;
    logic [1:0]            policy_reg;
    logic                  walloc_reg;
    logic [15:0]           lfsr_reg;
    logic [SETS-1:0]       set_valid_reg;
    in_item_t              item_reg;
    set_entry_t            set_rdata_reg;
    logic [SEEN_WIDTH-1:0] seen_rdata_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    set_entry_t            set_mem [SETS];
    logic [SEEN_WIDTH-1:0] seen_mem [SEEN_ROWS];

    logic                  in_xfer;
    logic                  fire;
    logic [BLOCK_BITS-1:0] block;
    logic [SET_BITS-1:0]   set_idx;
    set_entry_t            cur;
    set_entry_t            upd;
    logic                  hit;
    logic [WAY_BITS-1:0]   hit_way;
    logic [WAY_BITS-1:0]   victim;
    logic [WAY_BITS-1:0]   way_sel;
    logic [15:0]           lfsr_step;
    logic                  track;
    logic                  first;
    logic                  alloc;
    logic                  step_lfsr;
    out_item_t             res;
    logic                  seen_we;
    logic [ROW_BITS-1:0]   seen_waddr;
    logic [SEEN_WIDTH-1:0] seen_wdata;

    assign in_xfer   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign fire      = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);

    assign block   = item_reg.address[ADDR_BITS-1:OFFSET_BITS];
    assign set_idx = block[SET_BITS-1:0];

    // Set state as seen by this access; unwritten sets read as reset.
    always_comb
    begin
        cur = set_rdata_reg;
        if (!set_valid_reg[set_idx])
        begin
            cur.dirty    = '0;
            cur.fill     = '0;
            cur.fifo_ptr = '0;
            for (int i = 0; i < WAYS; i++)
            begin
                cur.recency[i] = WAY_BITS'(i);
            end
        end
    end

    // Tag compare over the filled ways.
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && (FILL_BITS'(w) < cur.fill)
                && (cur.line_addr[w][ADDR_BITS-1:OFFSET_BITS] == block))
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    // Victim choice by policy.
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[15:1]};
    always_comb
    begin
        case (policy_reg)
            POL_LRU:    victim = cur.recency[0];
            POL_RANDOM: victim = lfsr_step[WAY_BITS-1:0];
            POL_NMRU:   victim = (lfsr_step[WAY_BITS-1:0] == cur.recency[WAYS-1])
                                 ? lfsr_step[WAY_BITS-1:0] + 1'b1
                                 : lfsr_step[WAY_BITS-1:0];
            default:    victim = cur.fifo_ptr;
        endcase
    end

    // Update of the set word and the result.
    assign track = (policy_reg == POL_LRU) || (policy_reg == POL_NMRU);
    assign first = !seen_rdata_reg[block[SEEN_BITS-1:0]];
    assign alloc = !(item_reg.op == OP_WRITE && !walloc_reg);

    always_comb
    begin
        upd       = cur;
        step_lfsr = 1'b0;
        way_sel   = '0;
        res       = '0;
        if (hit)
        begin
            way_sel     = hit_way;
            res.outcome = OUT_HIT;
            if (item_reg.op == OP_WRITE)
            begin
                upd.dirty[hit_way] = 1'b1;
            end
            if (track)
            begin
                upd.recency = touch_order(cur.recency, hit_way);
            end
        end
        else
        begin
            res.outcome = first ? OUT_COMPULSORY
                        : ((SETS == 1) ? OUT_CAPACITY : OUT_CONFLICT);
            if (alloc)
            begin
                if (cur.fill < FILL_BITS'(WAYS))
                begin
                    way_sel  = cur.fill[WAY_BITS-1:0];
                    upd.fill = cur.fill + 1'b1;
                end
                else
                begin
                    way_sel = victim;
                    if (cur.dirty[victim])
                    begin
                        res.writeback_valid   = 1'b1;
                        res.writeback_address = cur.line_addr[victim];
                    end
                    if (policy_reg == POL_FIFO)
                    begin
                        upd.fifo_ptr = cur.fifo_ptr + 1'b1;
                    end
                    step_lfsr = (policy_reg == POL_RANDOM) || (policy_reg == POL_NMRU);
                end
                upd.line_addr[way_sel] = item_reg.address;
                upd.dirty[way_sel]     = item_reg.op;
                if (track)
                begin
                    upd.recency = touch_order(cur.recency, way_sel);
                end
            end
        end
        res.way = way_sel;
    end

    // Seen-block write port: clearing pass or marking the current block.
    always_comb
    begin
        seen_we    = 1'b0;
        seen_waddr = block[BLOCK_BITS-1:SEEN_BITS];
        seen_wdata = seen_rdata_reg;
        seen_wdata[block[SEEN_BITS-1:0]] = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            seen_we    = 1'b1;
            seen_waddr = clr_reg;
            seen_wdata = '0;
        end
        else if (fire)
        begin
            seen_we = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:   if (in_xfer) state_next = ST_LOOKUP;
            ST_LOOKUP: if (fire) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            set_rdata_reg  <= set_mem[in_data.address[OFFSET_BITS+SET_BITS-1:OFFSET_BITS]];
            seen_rdata_reg <= seen_mem[in_data.address[ADDR_BITS-1:OFFSET_BITS+SEEN_BITS]];
        end
        if (fire)
        begin
            set_mem[set_idx] <= upd;
        end
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            policy_reg    <= POL_LRU;
            walloc_reg    <= 1'b1;
            lfsr_reg      <= LFSR_SEED;
            set_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_REPL_POLICY)
                begin
                    policy_reg <= cfg_data;
                end
                else
                begin
                    walloc_reg <= cfg_data[0];
                end
            end
            if (fire)
            begin
                set_valid_reg[set_idx] <= 1'b1;
                if (step_lfsr)
                begin
                    lfsr_reg <= lfsr_step;
                end
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // No access is taken during the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("access accepted during clearing pass");

    // An accepted access is looked up in the next cycle.
    a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOOKUP))
        else $error("lookup did not follow an accepted access");

    // A result without writeback carries a zero writeback address.
    a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.writeback_valid) |-> (out_data.writeback_address == '0))
        else $error("writeback address set without writeback");

    // The fill count of a set never passes the number of ways.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> (cur.fill <= FILL_BITS'(WAYS)))
        else $error("set fill count out of range");
`endif

endmodule
`default_nettype wire

/* sim/set_assoc_cache_tag_controller_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core_tb: self-checking bench of the tag
// controller.
// Accesses are driven with random gaps and results are taken with random
// stalls. Each result is checked against an in-bench model of the sets,
// the replacement policies and the seen-block classification.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_core_tb;
    import sactc_pkg::*;

    localparam int QUEUE_DEPTH = 4096;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [1:0] cfg_data;

    set_assoc_cache_tag_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model of the cache state.
    logic [ADDR_BITS-1:0] mdl_addr [SETS][WAYS];
    logic                 mdl_dirty [SETS][WAYS];
    int                   mdl_fill [SETS];
    logic [WAY_BITS-1:0]  mdl_order [SETS][WAYS];
    logic [WAY_BITS-1:0]  mdl_fifo [SETS];
    bit                   mdl_seen [1 << BLOCK_BITS];
    logic [15:0]          mdl_lfsr;
    logic [1:0]           mdl_policy;
    logic                 mdl_walloc;

    // Pending accesses and expected results, kept as arrays with indexes.
    in_item_t  access_list [QUEUE_DEPTH];
    out_item_t expect_list [QUEUE_DEPTH];
    int        acc_wr;
    int        acc_rd;
    int        drv_idx;
    int        exp_wr;
    int        exp_rd;
    int        error_count;
    bit        hold_sender;
    int        send_gap;
    int        recv_gap;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Moves a way to the most recent end of its set.
    function automatic void model_touch(int set, logic [WAY_BITS-1:0] way);
        int p;
        p = WAYS - 1;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (mdl_order[set][i] == way)
            begin
                p = i;
            end
        end
        for (int i = p; i < WAYS - 1; i++)
        begin
            mdl_order[set][i] = mdl_order[set][i+1];
        end
        mdl_order[set][WAYS-1] = way;
    endfunction

    function automatic logic [15:0] lfsr_step();
        logic fb;
        fb = mdl_lfsr[0] ^ mdl_lfsr[2] ^ mdl_lfsr[3] ^ mdl_lfsr[5];
        mdl_lfsr = {fb, mdl_lfsr[15:1]};
        return mdl_lfsr;
    endfunction

    // Computes the result of one access and updates the model.
    function automatic out_item_t cache_access(in_item_t acc);
        out_item_t res;
        int blk;
        int set;
        bit first;
        bit hit;
        bit track;
        logic [WAY_BITS-1:0] way;
        logic [WAY_BITS-1:0] v;
        blk   = int'(acc.address >> OFFSET_BITS);
        set   = blk % SETS;
        first = !mdl_seen[blk];
        mdl_seen[blk] = 1'b1;
        track = (mdl_policy == POL_LRU) || (mdl_policy == POL_NMRU);
        hit = 1'b0;
        way = '0;
        res = '0;
        for (int w = 0; w < mdl_fill[set]; w++)
        begin
            if (!hit && (mdl_addr[set][w] >> OFFSET_BITS) == blk)
            begin
                hit = 1'b1;
                way = WAY_BITS'(w);
            end
        end
        if (hit)
        begin
            res.outcome = OUT_HIT;
            if (acc.op == OP_WRITE)
            begin
                mdl_dirty[set][way] = 1'b1;
            end
            if (track)
            begin
                model_touch(set, way);
            end
        end
        else
        begin
            res.outcome = first ? OUT_COMPULSORY : (SETS == 1 ? OUT_CAPACITY : OUT_CONFLICT);
            if (!(acc.op == OP_WRITE && !mdl_walloc))
            begin
                if (mdl_fill[set] < WAYS)
                begin
                    way = WAY_BITS'(mdl_fill[set]);
                    mdl_fill[set]++;
                end
                else
                begin
                    case (mdl_policy)
                        POL_LRU:    way = mdl_order[set][0];
                        POL_RANDOM: way = WAY_BITS'(lfsr_step());
                        POL_NMRU:
                        begin
                            v = WAY_BITS'(lfsr_step());
                            if (v == mdl_order[set][WAYS-1])
                            begin
                                v = v + 1'b1;
                            end
                            way = v;
                        end
                        default:
                        begin
                            way = mdl_fifo[set];
                            mdl_fifo[set] = way + 1'b1;
                        end
                    endcase
                    if (mdl_dirty[set][way])
                    begin
                        res.writeback_valid   = 1'b1;
                        res.writeback_address = mdl_addr[set][way];
                    end
                end
                mdl_addr[set][way]  = acc.address;
                mdl_dirty[set][way] = acc.op;
                if (track)
                begin
                    model_touch(set, way);
                end
            end
        end
        res.way = way;
        return res;
    endfunction

    // Input transfers: predict the result at the accepting edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expect_list[exp_wr % QUEUE_DEPTH] = cache_access(in_data);
            exp_wr++;
            acc_rd++;
        end
    end

    // Driver: presents queued accesses after a random gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid)
            begin
                if (acc_rd != drv_idx)
                begin
                    send_gap = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end
            end
            else if (!hold_sender && acc_rd < acc_wr)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else
                begin
                    drv_idx = acc_rd;
                    in_data  <= access_list[acc_rd % QUEUE_DEPTH];
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_rd == exp_wr)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                error_count++;
            end
            else if (out_data !== expect_list[exp_rd % QUEUE_DEPTH])
            begin
                $display("%0t: result mismatch, expected %h, actual %h",
                         $time, expect_list[exp_rd % QUEUE_DEPTH], out_data);
                error_count++;
                exp_rd++;
            end
            else
            begin
                exp_rd++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (out_ready && out_valid)
        begin
            recv_gap = $urandom_range(0, 5);
            out_ready <= (recv_gap == 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Adds one access to the pending list.
    task automatic queue_access(in_item_t acc);
        access_list[acc_wr % QUEUE_DEPTH] = acc;
        acc_wr++;
    endtask

    // Waits until every queued access has been sent and checked.
    task automatic drain();
        while (acc_rd < acc_wr || in_valid || exp_rd != exp_wr)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Configuration write, issued only while no access is in flight.
    task automatic write_reg(logic idx, logic [1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_REPL_POLICY)
        begin
            mdl_policy = value;
        end
        else
        begin
            mdl_walloc = value[0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random access, mostly into a few sets and tags so that hits and
    // replacements are frequent.
    function automatic in_item_t random_access();
        in_item_t a;
        a.op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8)
        begin
            a.address = ADDR_BITS'(($urandom_range(0, 7) << 14)
                        | ($urandom_range(0, 3) << OFFSET_BITS) | $urandom_range(0, 15));
            a.address[ADDR_BITS-1] = 1'($urandom_range(0, 1));
        end
        else
        begin
            a.address = ADDR_BITS'($urandom);
        end
        return a;
    endfunction

    initial
    begin
        in_item_t a;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_REPL_POLICY;
        cfg_data = '0;
        error_count = 0;
        hold_sender = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        acc_wr = 0;
        acc_rd = 0;
        drv_idx = -1;
        exp_wr = 0;
        exp_rd = 0;
        for (int s = 0; s < SETS; s++)
        begin
            mdl_fill[s] = 0;
            mdl_fifo[s] = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                mdl_addr[s][w]  = '0;
                mdl_dirty[s][w] = 1'b0;
                mdl_order[s][w] = WAY_BITS'(w);
            end
        end
        mdl_lfsr   = LFSR_SEED;
        mdl_policy = POL_LRU;
        mdl_walloc = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, fill and evict one set with dirty lines.
        write_reg(CFG_REPL_POLICY, POL_LRU);
        write_reg(CFG_WRITE_ALLOCATE, 2'd1);
        queue_access('{op: 1'b0, address: 20'h00000});
        queue_access('{op: 1'b1, address: 20'hFFFFF});
        queue_access('{op: 1'b1, address: 20'h0000F});
        for (int i = 1; i <= 5; i++)
        begin
            queue_access('{op: 1'b1, address: 20'(i << 10)});
        end
        queue_access('{op: 1'b0, address: 20'h00000});
        queue_access('{op: 1'b0, address: 20'h00400});
        drain();
        write_reg(CFG_WRITE_ALLOCATE, 2'd0);
        queue_access('{op: 1'b1, address: 20'h55550});
        queue_access('{op: 1'b0, address: 20'h55550});
        queue_access('{op: 1'b1, address: 20'hAAAA0});
        drain();

        // Random phases across every policy and allocation setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_REPL_POLICY, 2'(ph % 4));
            write_reg(CFG_WRITE_ALLOCATE, (ph / 4 == 0) ? 2'd1 : 2'd0);
            for (int i = 0; i < 175; i++)
            begin
                a = random_access();
                queue_access(a);
            end
            if (ph == 2)
            begin
                while (acc_wr - acc_rd > 100)
                begin
                    @(posedge clk);
                end
                hold_sender = 1'b1;
                while (exp_rd != exp_wr || in_valid)
                begin
                    @(posedge clk);
                end
                hold_sender = 1'b0;
            end
            drain();
        end
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
